// ===== rtl/core/keypad_to_segment_display_macros.svh =====
// ----------------------------------------------------------------------------
// keypad_to_segment_display_macros.svh
// Assertion macros shared by the keypad/display RTL. They expect signals
// named clock and reset in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_TO_SEGMENT_DISPLAY_MACROS_SVH
`define KEYPAD_TO_SEGMENT_DISPLAY_MACROS_SVH

// Property holds on every clock edge outside reset.
`define KPSD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Consequent holds on the edge after the antecedent.
`define KPSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/kpsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsd_pkg
// Types, codes and constant tables of the keypad to seven-segment controller.
// ----------------------------------------------------------------------------
package kpsd_pkg;

   localparam int DIGITS   = 4;
   localparam int ROWS     = 4;
   localparam int COLS     = 4;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] digit_sel_type;
   typedef logic [1:0] scan_pos_type;
   typedef logic       cmd_type;

   localparam cmd_type CMD_KEY  = 1'b0;   // keypad port change beat
   localparam cmd_type CMD_TICK = 1'b1;   // display scan tick beat

   localparam byte_type RESET_DIGIT   = 8'h7F;
   localparam byte_type RESET_PENDING = 8'hC0;

   // sample patterns that identify the pressed row
   localparam byte_type ROW_PATTERN [ROWS] = '{8'hDF, 8'hBF, 8'h7F, 8'hEF};

   // row drive per scan position
   localparam byte_type SCAN_ROW [DIGITS] = '{8'hEF, 8'hDF, 8'hBF, 8'h7F};

   // active-low segment codes, [row][column]
   localparam byte_type KEY_CODE [ROWS][COLS] = '{
      '{8'hF9, 8'hA4, 8'hB0, 8'h88},
      '{8'h99, 8'h92, 8'h82, 8'h83},
      '{8'hF8, 8'h80, 8'h90, 8'hC6},
      '{8'h8F, 8'hC0, 8'h89, 8'hA1}
   };

   // decoder result passed to the top level
   typedef struct packed {
      logic     hit;
      byte_type code;
   } key_hit_type;

endpackage

// ===== rtl/core/kpsd_channels_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsd_channels_if
// Valid/ready channels: keypad/tick request and display scan response.
// ----------------------------------------------------------------------------
interface kpsd_req_if;
   import kpsd_pkg::*;

   logic     valid;
   logic     ready;
   cmd_type  cmd;
   byte_type port_sample;

   modport source (output valid, output cmd, output port_sample, input ready);
   modport sink   (input valid, input cmd, input port_sample, output ready);
endinterface

interface kpsd_rsp_if;
   import kpsd_pkg::*;

   logic          valid;
   logic          ready;
   digit_sel_type digit_select;
   byte_type      segments;
   byte_type      row_drive;

   modport source (output valid, output digit_select, output segments,
                   output row_drive, input ready);
   modport sink   (input valid, input digit_select, input segments,
                   input row_drive, output ready);
endinterface

// ===== rtl/core/kpsd_key_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsd_key_decode
// Row match and lowest changed column lookup for one keypad port sample.
// ----------------------------------------------------------------------------
module kpsd_key_decode (
   input  kpsd_pkg::byte_type    sample,
   input  kpsd_pkg::byte_type    last_sample,
   output kpsd_pkg::key_hit_type key_hit
);
   import kpsd_pkg::*;

   logic [COLS-1:0] changed;

   assign changed = sample[COLS-1:0] ^ last_sample[COLS-1:0];

   always_comb begin
      key_hit = '{hit: 1'b0, code: RESET_PENDING};
      for (int r = 0; r < ROWS; r++) begin
         if (sample == ROW_PATTERN[r]) begin
            // lowest changed column wins; scan from the top down
            for (int c = COLS - 1; c >= 0; c--) begin
               if (changed[c]) begin
                  key_hit.hit  = 1'b1;
                  key_hit.code = KEY_CODE[r][c];
               end
            end
         end
      end
   end

endmodule

// ===== rtl/core/keypad_to_segment_display.sv =====
`timescale 1ns / 1ps
`include "keypad_to_segment_display_macros.svh"
// ----------------------------------------------------------------------------
// keypad_to_segment_display
// 4x4 keypad decoder driving a four-digit multiplexed seven-segment display.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  req_bus  in   valid/ready        cmd, port_sample
//  rsp_bus  out  valid/ready        digit_select, segments, row_drive
//
//  One beat a cycle is taken sustained while req ready is high. A beat lands
//  in the input register and is worked from there; a tick's result is loaded
//  into the response register at the end of the cycle in which it is worked.
//  Reset (synchronous, active high) clears both valid flags and puts the
//  digit line, pending code, last sample, flags and scan position to their
//  power-on values.
//  Key beats never wait in the input register. A tick beat waits there only
//  while the previous result is still held and not taken; req ready then
//  drops, so any beat behind it waits too.
//
module keypad_to_segment_display (
   input logic        clock,
   input logic        reset,
   kpsd_req_if.sink   req_bus,
   kpsd_rsp_if.source rsp_bus
);
   import kpsd_pkg::*;

   // input register
   logic     s1_valid_ff, s1_valid_in;
   cmd_type  s1_cmd_ff;
   byte_type s1_sample_ff;

   // block state
   byte_type     digit_codes_ff [DIGITS];   // entry 0 newest, 3 oldest
   byte_type     digit_codes_in [DIGITS];
   byte_type     pending_code_ff, pending_code_in;
   byte_type     last_sample_ff, last_sample_in;
   logic         change_pending_ff, change_pending_in;
   logic         hold_flag_ff, hold_flag_in;
   scan_pos_type scan_pos_ff, scan_pos_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   digit_sel_type digit_select_ff, digit_select_in;
   byte_type      segments_ff, segments_in;
   byte_type      row_drive_ff, row_drive_in;

   logic        s1_advance;
   logic        key_fire;
   logic        tick_fire;
   logic        do_shift;
   logic        cp_mid;
   logic        hold_mid;
   key_hit_type key_hit;
   byte_type    sel_row;

   kpsd_key_decode u_key_decode (
      .sample      (s1_sample_ff),
      .last_sample (last_sample_ff),
      .key_hit     (key_hit)
   );

   // the input register moves on unless a tick would land on a held result
   assign s1_advance = !s1_valid_ff || (s1_cmd_ff == CMD_KEY) ||
                       !rsp_valid_ff || rsp_bus.ready;
   assign key_fire   = s1_valid_ff && s1_advance && (s1_cmd_ff == CMD_KEY);
   assign tick_fire  = s1_valid_ff && s1_advance && (s1_cmd_ff == CMD_TICK);

   assign req_bus.ready = s1_advance;

   assign s1_valid_in = req_bus.valid ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   // tick: shift when a change waits and no hold, then settle the flags
   assign do_shift = change_pending_ff && !hold_flag_ff;
   assign cp_mid   = do_shift ? 1'b0 : change_pending_ff;
   assign hold_mid = do_shift ? 1'b1 : hold_flag_ff;

   always_comb begin
      digit_codes_in    = digit_codes_ff;
      pending_code_in   = pending_code_ff;
      last_sample_in    = last_sample_ff;
      change_pending_in = change_pending_ff;
      hold_flag_in      = hold_flag_ff;
      scan_pos_in       = scan_pos_ff;

      if (key_fire) begin
         last_sample_in = s1_sample_ff;
         if (key_hit.hit) begin
            pending_code_in   = key_hit.code;
            change_pending_in = 1'b1;
         end
      end

      if (tick_fire) begin
         if (do_shift) begin
            for (int i = DIGITS - 1; i > 0; i--) begin
               digit_codes_in[i] = digit_codes_ff[i-1];
            end
            digit_codes_in[0] = pending_code_ff;
         end
         scan_pos_in       = scan_pos_ff + 2'd1;
         change_pending_in = cp_mid;
         hold_flag_in      = hold_mid;
         if (cp_mid && hold_mid) begin
            change_pending_in = 1'b0;
         end else if (!cp_mid && hold_mid) begin
            hold_flag_in = 1'b0;
         end
      end
   end

   // result for the new position; digit 3-pos is the bitwise inverse of pos
   always_comb begin
      digit_select_in = digit_sel_type'(1) << scan_pos_in;
      segments_in     = digit_codes_in[~scan_pos_in];
      row_drive_in    = SCAN_ROW[scan_pos_in];
   end

   assign rsp_valid_in = tick_fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         pending_code_ff   <= RESET_PENDING;
         last_sample_ff    <= '0;
         change_pending_ff <= 1'b0;
         hold_flag_ff      <= 1'b0;
         scan_pos_ff       <= '0;
         for (int i = 0; i < DIGITS; i++) begin
            digit_codes_ff[i] <= RESET_DIGIT;
         end
      end else begin
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         pending_code_ff   <= pending_code_in;
         last_sample_ff    <= last_sample_in;
         change_pending_ff <= change_pending_in;
         hold_flag_ff      <= hold_flag_in;
         scan_pos_ff       <= scan_pos_in;
         digit_codes_ff    <= digit_codes_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_bus.valid && s1_advance) begin
         s1_cmd_ff    <= req_bus.cmd;
         s1_sample_ff <= req_bus.port_sample;
      end
      if (tick_fire) begin
         digit_select_ff <= digit_select_in;
         segments_ff     <= segments_in;
         row_drive_ff    <= row_drive_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.digit_select = digit_select_ff;
   assign rsp_bus.segments     = segments_ff;
   assign rsp_bus.row_drive    = row_drive_ff;

   // ---- checks ----
   // row drive implied by the digit select: low nibble clear, inverted
   assign sel_row = ~{digit_select_ff, 4'h0};

   `KPSD_ASSERT(a_sel_onehot, !rsp_valid_ff || $onehot(digit_select_ff), "select not one-hot")
   `KPSD_ASSERT(a_row_sel, !rsp_valid_ff || (row_drive_ff == sel_row), "row drive off digit")
   `KPSD_ASSERT_NEXT(a_tick_gives_result, tick_fire, rsp_valid_ff, "tick beat left no result")
   `KPSD_ASSERT(a_hold_never_left_set, !hold_flag_ff, "hold flag survived a tick")

endmodule
